[hdl/efsp_pkg.sv]
// Shared constants for the earliest free server picker.
// Field widths of the stream and configuration words; no dependencies.
package efsp_pkg;

    localparam int SVC_BITS     = 16;
    localparam int IDX_OUT_BITS = 4;
    localparam int CFG_BITS     = 5;

    localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

    typedef logic [SVC_BITS-1:0]     svc_t;
    typedef logic [IDX_OUT_BITS-1:0] idx_out_t;
    typedef logic [CFG_BITS-1:0]     cfg_t;

endpackage

[hdl/earliest_free_server_picker_unit.sv]
// Earliest free server picker: each job word goes to the server in use that is free soonest
// (lowest index on a tie), whose free time then grows by the service time, saturating at
// the top of the time range. A job is accepted only in the idle state; it then makes one
// pass over the free-time RAM through its single read port, one server at a time behind
// the RAM's registered read, and then an update step that writes the new free time and
// waits while the output register still holds an untaken result. The next server is
// found in the same pass by tracking the runner-up. The result sits in an output
// register, so a new job may be accepted while it waits. Free times are held in efsp_ram;
// per-server valid flags make cleared entries read as zero. Uses efsp_pkg and efsp_ram.
module earliest_free_server_picker_unit
    import efsp_pkg::*;
#(
    parameter int MAX_SERVERS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] service_time
    input  logic        s_axis_tuser,   // [0] start_case
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] assigned_server, [7:4] next_server,
                                        // [8] time_saturated, [15:9] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data        // [4:0] server_count
);

    localparam int IDXW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int NW   = $clog2(MAX_SERVERS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [IDXW-1:0]      idx_t;
    typedef logic [NW-1:0]        cnt_t;

    logic [1:0]             state_reg, state_next;
    cfg_t                   count_reg;
    cnt_t                   n_reg, n_next;
    cnt_t                   cnt_reg, cnt_next;
    svc_t                   svc_reg, svc_next;
    logic [MAX_SERVERS-1:0] valid_reg, valid_next;
    logic                   vrd_reg;
    time_t                  best_v_reg, best_v_next;
    idx_t                   best_i_reg, best_i_next;
    time_t                  sec_v_reg, sec_v_next;
    idx_t                   sec_i_reg, sec_i_next;
    logic                   have_sec_reg, have_sec_next;
    logic                   m_valid_reg, m_valid_next;
    logic [15:0]            m_data_reg, m_data_next;

    logic                   in_acc;
    logic                   rd_en;
    idx_t                   rd_addr;
    time_t                  rd_data;
    time_t                  cur_v;
    idx_t                   cur_i;
    logic                   wr_en;
    time_t                  wr_data;
    logic [TIME_BITS:0]     sum_full;
    logic                   sat;
    logic                   pick_next_self;
    idx_t                   nxt_i;
    logic [IDXW+IDX_OUT_BITS-1:0] pick_ext, nxt_ext;
    cnt_t                   n_active;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_comb
    begin
        if (count_reg == '0)
        begin
            n_active = cnt_t'(1);
        end
        else if (int'(count_reg) > MAX_SERVERS)
        begin
            n_active = cnt_t'(MAX_SERVERS);
        end
        else
        begin
            n_active = cnt_t'(count_reg);
        end
    end

    assign rd_en   = (state_reg == S_SCAN) && (cnt_reg < n_reg);
    assign rd_addr = idx_t'(cnt_reg);
    assign cur_v   = vrd_reg ? rd_data : '0;
    assign cur_i   = idx_t'(cnt_reg - cnt_t'(1));

    assign sum_full = {1'b0, best_v_reg} + {{(TIME_BITS + 1 - SVC_BITS){1'b0}}, svc_reg};
    assign sat      = sum_full[TIME_BITS];
    assign wr_data  = sat ? {TIME_BITS{1'b1}} : sum_full[TIME_BITS-1:0];

    assign pick_next_self = !have_sec_reg || (wr_data < sec_v_reg) ||
                            ((wr_data == sec_v_reg) && (best_i_reg < sec_i_reg));
    assign nxt_i    = pick_next_self ? best_i_reg : sec_i_reg;
    assign pick_ext = {{IDX_OUT_BITS{1'b0}}, best_i_reg};
    assign nxt_ext  = {{IDX_OUT_BITS{1'b0}}, nxt_i};

    efsp_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_SERVERS)
    ) u_free_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (best_i_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        svc_next      = svc_reg;
        valid_next    = valid_reg;
        best_v_next   = best_v_reg;
        best_i_next   = best_i_reg;
        sec_v_next    = sec_v_reg;
        sec_i_next    = sec_i_reg;
        have_sec_next = have_sec_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        wr_en         = 1'b0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    svc_next      = s_axis_tdata;
                    n_next        = n_active;
                    cnt_next      = '0;
                    have_sec_next = 1'b0;
                    if (s_axis_tuser)
                    begin
                        valid_next = '0;
                    end
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == cnt_t'(1))
                begin
                    best_v_next = cur_v;
                    best_i_next = cur_i;
                end
                else if (cnt_reg != '0)
                begin
                    if (cur_v < best_v_reg)
                    begin
                        sec_v_next    = best_v_reg;
                        sec_i_next    = best_i_reg;
                        have_sec_next = 1'b1;
                        best_v_next   = cur_v;
                        best_i_next   = cur_i;
                    end
                    else if (!have_sec_reg || (cur_v < sec_v_reg))
                    begin
                        sec_v_next    = cur_v;
                        sec_i_next    = cur_i;
                        have_sec_next = 1'b1;
                    end
                end
                cnt_next = cnt_reg + cnt_t'(1);
                if (cnt_reg == n_reg)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    wr_en                  = 1'b1;
                    valid_next[best_i_reg] = 1'b1;
                    m_valid_next           = 1'b1;
                    m_data_next = {7'd0, sat, nxt_ext[IDX_OUT_BITS-1:0],
                                   pick_ext[IDX_OUT_BITS-1:0]};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= CFG_RESET;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
            have_sec_reg <= 1'b0;
            cnt_reg      <= '0;
            n_reg        <= cnt_t'(1);
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            m_valid_reg  <= m_valid_next;
            have_sec_reg <= have_sec_next;
            cnt_reg      <= cnt_next;
            n_reg        <= n_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        svc_reg    <= svc_next;
        best_v_reg <= best_v_next;
        best_i_reg <= best_i_next;
        sec_v_reg  <= sec_v_next;
        sec_i_reg  <= sec_i_next;
        m_data_reg <= m_data_next;
        vrd_reg    <= valid_reg[rd_addr];
    end

    a_rise_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg) == S_UPD)
        else $error("result raised outside update");

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> ({1'b0, best_i_reg} < {1'b0, n_reg}))
        else $error("picked server outside active count");

    a_n_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (n_reg != '0))
        else $error("active server count is zero");

    a_sec_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD && have_sec_reg) |-> (sec_i_reg != best_i_reg))
        else $error("runner-up equals chosen server");

endmodule

[hdl/efsp_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module efsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

[dv/tb_top.sv]
// Testbench for earliest_free_server_picker_unit: directed, single-server, back-pressure and
// random job streams, each result checked against an in-bench model of the server free times.
// Depends on efsp_pkg and the unit under test only.
module tb_top
    import efsp_pkg::*;
();

    localparam int SERVERS     = 16;
    localparam int TIME_W      = 32;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_JOBS  = 146;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [6:0] pad;
        logic       saturated;
        idx_out_t   next_srv;
        idx_out_t   assigned;
    } pick_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;

    logic [TIME_W-1:0] free_time [SERVERS];
    cfg_t              server_count_q;
    pick_word_t        expected_picks [$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  jobs_sent;
    int  count_writes;
    int  rx_stall = 0;
    bit  rx_hold_seen = 1'b0;
    bit  rx_idle_on;
    bit  rx_hold_ask;
    bit  tx_idle_on;

    earliest_free_server_picker_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int soonest_free(input int n);
        int best;
        best = 0;
        for (int i = 1; i < n; i++)
        begin
            if (free_time[i] < free_time[best])
                best = i;
        end
        return best;
    endfunction

    function automatic pick_word_t place_job(input logic start, input svc_t svc);
        int          n;
        int          pick;
        int          nxt;
        logic [TIME_W:0] sum;
        pick_word_t  w;
        if (server_count_q == 0)
            n = 1;
        else if (server_count_q > SERVERS)
            n = SERVERS;
        else
            n = server_count_q;
        if (start)
        begin
            for (int i = 0; i < SERVERS; i++)
                free_time[i] = '0;
        end
        pick = soonest_free(n);
        sum = {1'b0, free_time[pick]} + svc;
        w = '0;
        w.saturated = sum[TIME_W];
        free_time[pick] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        nxt = soonest_free(n);
        w.assigned = pick[IDX_OUT_BITS-1:0];
        w.next_srv = nxt[IDX_OUT_BITS-1:0];
        return w;
    endfunction

    task automatic send_job(input logic start, input svc_t svc, input int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= start;
        s_axis_tdata  <= svc;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_picks.push_back(place_job(start, svc));
        jobs_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_server_count(input cfg_t value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        server_count_q = value;
        count_writes++;
    endtask

    function automatic int tx_gap();
        return tx_idle_on ? gap_len() : 0;
    endfunction

    // Receiver readiness; a newly raised hold request stalls it, and random stalls are optional.
    always @(posedge clk)
    begin
        if (rx_hold_ask && !rx_hold_seen)
        begin
            rx_hold_seen = 1'b1;
            rx_stall = HOLD_CYCLES;
        end
        if (!rx_hold_ask)
            rx_hold_seen = 1'b0;
        if (rx_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (rx_idle_on && $urandom_range(0, 2) == 0)
                rx_stall = gap_len();
        end
    end

    always @(posedge clk)
    begin
        pick_word_t exp_w;
        pick_word_t got_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_w = m_axis_tdata;
            if (expected_picks.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected result word %h", $time, m_axis_tdata);
            end
            else
            begin
                exp_w = expected_picks.pop_front();
                if (got_w !== exp_w)
                begin
                    error_count++;
                    $display("%0t mismatch: exp srv %0d next %0d sat %0b pad %h,",
                             $time, exp_w.assigned, exp_w.next_srv, exp_w.saturated,
                             exp_w.pad);
                    $display("%0t           got srv %0d next %0d sat %0b pad %h",
                             $time, got_w.assigned, got_w.next_srv, got_w.saturated,
                             got_w.pad);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results outstanding", $time, expected_picks.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic test_ties_and_extremes();
        send_job(1'b0, 16'h0000, 0);
        send_job(1'b0, 16'hFFFF, 0);
        send_job(1'b0, 16'h0001, 1);
        send_job(1'b0, 16'h8000, 0);
        send_job(1'b1, 16'h0001, 2);
        send_job(1'b1, 16'h0000, 0);
        send_job(1'b0, 16'h5555, 0);
        send_job(1'b0, 16'hAAAA, 3);
    endtask

    task automatic test_count_limits();
        write_server_count(5'd0);
        send_job(1'b1, 16'd7, 0);
        send_job(1'b0, 16'd3, 0);
        write_server_count(5'd31);
        send_job(1'b0, 16'd2, 0);
        send_job(1'b0, 16'd9, 0);
        write_server_count(5'd17);
        send_job(1'b0, 16'd1, 0);
        write_server_count(5'd1);
        send_job(1'b1, 16'hFFFF, 0);
    endtask

    task automatic test_count_change_mid_case();
        write_server_count(5'd4);
        send_job(1'b1, 16'd10, 0);
        send_job(1'b0, 16'd20, 0);
        send_job(1'b0, 16'd30, 0);
        send_job(1'b0, 16'd40, 0);
        write_server_count(5'd2);
        send_job(1'b0, 16'd5, 0);
        send_job(1'b0, 16'd5, 0);
        write_server_count(5'd8);
        send_job(1'b0, 16'd1, 0);
        send_job(1'b0, 16'd1, 0);
    endtask

    // One server loaded back to back, mostly with the longest jobs.
    task automatic test_single_server_load();
        write_server_count(5'd1);
        send_job(1'b1, 16'hFFFF, 0);
        for (int k = 0; k < 30; k++)
            send_job(1'b0, 16'hFFFF, 0);
        send_job(1'b0, 16'h0000, 0);
        send_job(1'b0, 16'h0001, 0);
        send_job(1'b0, 16'h0000, 0);
        send_job(1'b0, 16'hFFFF, 0);
    endtask

    task automatic test_backpressure();
        write_server_count(5'd16);
        rx_hold_ask <= 1'b1;
        for (int k = 0; k < 40; k++)
            send_job(k == 0, svc_t'($urandom_range(0, 65535)), 0);
        rx_hold_ask <= 1'b0;
    endtask

    task automatic test_random_streams();
        cfg_t extremes [6];
        cfg_t count_val;
        svc_t svc;
        logic start;
        int   r;
        extremes = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd2};
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            count_val = (p < 6) ? extremes[p] : cfg_t'($urandom_range(0, 31));
            write_server_count(count_val);
            tx_idle_on = (p % 3) != 2;
            rx_idle_on <= (p % 4) != 3;
            for (int k = 0; k < PHASE_JOBS; k++)
            begin
                start = (k == 0) || ($urandom_range(0, 24) == 0);
                r = $urandom_range(0, 9);
                if (r < 3)
                    svc = svc_t'($urandom_range(0, 15));
                else if (r == 3)
                    svc = 16'h0000;
                else if (r == 4)
                    svc = 16'hFFFF;
                else
                    svc = svc_t'($urandom_range(0, 65535));
                send_job(start, svc, tx_gap());
            end
        end
        rx_idle_on <= 1'b0;
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        jobs_sent      = 0;
        count_writes   = 0;
        rx_idle_on     = 1'b0;
        rx_hold_ask    = 1'b0;
        tx_idle_on     = 1'b0;
        server_count_q = CFG_RESET;
        for (int i = 0; i < SERVERS; i++)
            free_time[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ties_and_extremes();
        test_count_limits();
        test_count_change_mid_case();
        test_single_server_load();
        test_backpressure();
        test_random_streams();
        wait_idle();

        $display("summary: %0d jobs over %0d server-count writes, counts 0 to 31,", jobs_sent,
                 count_writes);
        $display("summary: ties, case restarts, long single-server runs and a receiver hold-off");
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
